### design/sqpv_pkg.sv
// Package for the Stokes Q/U polarization vector block.
// Holds widths, fixed-point constants, the CORDIC arctangent table and shared types.
// No dependencies.
`timescale 1ns / 1ps

package sqpv_pkg;

    // Sample and fixed-point formats
    localparam int SAMPLE_WIDTH  = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int GUARD_BITS    = 14;
    localparam int ATAN_ENTRIES  = 32;
    localparam int N_STAGES      = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES
                                                                  : ATAN_ENTRIES;
    localparam int SIW           = $clog2(ATAN_ENTRIES);

    // Datapath: sample << GUARD_BITS plus headroom for CORDIC gain and sqrt(2)
    localparam int DW  = SAMPLE_WIDTH + GUARD_BITS + 3;
    localparam int MW  = DW - 1;
    // Angle in 2^-32 turn, plus headroom
    localparam int AW  = 34;

    // Gain removal
    localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;
    localparam int HIW  = MW - 16 + 32;
    localparam int LOPW = 16 + 32;
    localparam int LOW  = LOPW - 16;
    localparam int ACCW = HIW + 1;
    localparam int RSH  = 16 + GUARD_BITS;
    localparam int RESW = ACCW - RSH;

    // Result fields
    localparam int TH_W      = 16;
    localparam int PH_W      = 17;
    localparam int THETA_MAX = 46341;
    localparam int PHI_LIMIT = 32768;

    // Stream widths
    localparam int S_DATA_W = 2 * SAMPLE_WIDTH;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = ((TH_W + PH_W + 7) / 8) * 8;
    localparam int M_USER_W = 1;

    typedef logic signed [DW-1:0] data_t;
    typedef logic signed [AW-1:0] angle_t;

    // Pipeline token: slot occupied, both samples present
    typedef struct packed {
        logic valid;
        logic ok;
    } tok_t;

    // Vectoring cell payload; x0/y0 ride along for the rotation chain
    typedef struct packed {
        data_t  x;
        data_t  y;
        angle_t z;
        data_t  x0;
        data_t  y0;
    } vec_t;

    // Rotation cell payload; r is the negated residual angle
    typedef struct packed {
        data_t  x;
        data_t  y;
        angle_t r;
    } rot_t;

    typedef struct packed {
        logic                   vector_valid;
        logic [TH_W-1:0]        theta;
        logic signed [PH_W-1:0] phi;
    } res_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic angle_t atan_turn(input logic [SIW-1:0] idx);
        angle_t a;
        case (idx)
            5'd0:    a = AW'(32'h20000000);
            5'd1:    a = AW'(32'h12E4051D);
            5'd2:    a = AW'(32'h09FB385B);
            5'd3:    a = AW'(32'h051111D4);
            5'd4:    a = AW'(32'h028B0D43);
            5'd5:    a = AW'(32'h0145D7E1);
            5'd6:    a = AW'(32'h00A2F61E);
            5'd7:    a = AW'(32'h00517C55);
            5'd8:    a = AW'(32'h0028BE53);
            5'd9:    a = AW'(32'h00145F2E);
            5'd10:   a = AW'(32'h000A2F98);
            5'd11:   a = AW'(32'h000517CC);
            5'd12:   a = AW'(32'h00028BE6);
            5'd13:   a = AW'(32'h000145F3);
            5'd14:   a = AW'(32'h0000A2F9);
            5'd15:   a = AW'(32'h0000517C);
            5'd16:   a = AW'(32'h000028BE);
            5'd17:   a = AW'(32'h0000145F);
            5'd18:   a = AW'(32'h00000A2F);
            5'd19:   a = AW'(32'h00000517);
            5'd20:   a = AW'(32'h0000028B);
            5'd21:   a = AW'(32'h00000145);
            5'd22:   a = AW'(32'h000000A2);
            5'd23:   a = AW'(32'h00000051);
            5'd24:   a = AW'(32'h00000028);
            5'd25:   a = AW'(32'h00000014);
            5'd26:   a = AW'(32'h0000000A);
            5'd27:   a = AW'(32'h00000005);
            5'd28:   a = AW'(32'h00000002);
            5'd29:   a = AW'(32'h00000001);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

### design/sqpv_vec_cell.sv
// One vectoring CORDIC cell: a single micro-rotation driving y toward zero.
// Depends on sqpv_pkg.
`timescale 1ns / 1ps

module sqpv_vec_cell
    import sqpv_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic [SIW-1:0] stage_idx,
    input  tok_t           tok_in,
    input  vec_t           d_in,
    output tok_t           tok_out,
    output vec_t           d_out
);

    tok_t   tok_reg;
    vec_t   d_reg;
    vec_t   d_next;
    data_t  xs;
    data_t  ys;
    angle_t a;

    // Micro-rotation; shifts floor toward minus infinity
    always_comb
    begin
        xs     = d_in.x >>> stage_idx;
        ys     = d_in.y >>> stage_idx;
        a      = atan_turn(stage_idx);
        d_next = d_in;
        if (!d_in.y[DW-1])
        begin
            d_next.x = d_in.x + ys;
            d_next.y = d_in.y - xs;
            d_next.z = d_in.z + a;
        end
        else
        begin
            d_next.x = d_in.x - ys;
            d_next.y = d_in.y + xs;
            d_next.z = d_in.z - a;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else if (en)
            tok_reg <= tok_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d_reg <= d_next;
    end

    assign tok_out = tok_reg;
    assign d_out   = d_reg;

endmodule

### design/sqpv_rot_cell.sv
// One rotation CORDIC cell: a single micro-rotation driving the residual angle to zero.
// Depends on sqpv_pkg.
`timescale 1ns / 1ps

module sqpv_rot_cell
    import sqpv_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic [SIW-1:0] stage_idx,
    input  tok_t           tok_in,
    input  rot_t           d_in,
    output tok_t           tok_out,
    output rot_t           d_out
);

    tok_t   tok_reg;
    rot_t   d_reg;
    rot_t   d_next;
    data_t  xs;
    data_t  ys;
    angle_t a;
    logic   r_le_zero;

    // r holds minus the remaining angle: rotate positive while r <= 0
    always_comb
    begin
        xs        = d_in.x >>> stage_idx;
        ys        = d_in.y >>> stage_idx;
        a         = atan_turn(stage_idx);
        r_le_zero = d_in.r[AW-1] || (d_in.r == '0);
        if (r_le_zero)
        begin
            d_next.x = d_in.x - ys;
            d_next.y = d_in.y + xs;
            d_next.r = d_in.r + a;
        end
        else
        begin
            d_next.x = d_in.x + ys;
            d_next.y = d_in.y - xs;
            d_next.r = d_in.r - a;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else if (en)
            tok_reg <= tok_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d_reg <= d_next;
    end

    assign tok_out = tok_reg;
    assign d_out   = d_reg;

endmodule

### design/sqpv_gain.sv
// Gain removal: three stages that scale the rotated vector by 1/K, round to Q1.15,
// saturate and zero the result of null pixels. Depends on sqpv_pkg.
`timescale 1ns / 1ps

module sqpv_gain
    import sqpv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  tok_t tok_in,
    input  rot_t d_in,
    output tok_t tok_out,
    output res_t res_out
);

    tok_t            tok1_reg;
    tok_t            tok2_reg;
    tok_t            tok3_reg;
    logic [MW-1:0]   xpos_reg;
    logic [MW-1:0]   ymag_reg;
    logic            yneg1_reg;
    logic [MW-1:0]   xpos_next;
    logic [MW-1:0]   ymag_next;
    logic [HIW-1:0]  th_hi_reg;
    logic [LOW-1:0]  th_lo_reg;
    logic [HIW-1:0]  p_hi_reg;
    logic [LOW-1:0]  p_lo_reg;
    logic            yneg2_reg;
    logic [LOPW-1:0] th_lo_prod;
    logic [LOPW-1:0] p_lo_prod;
    logic [ACCW-1:0] th_acc;
    logic [ACCW-1:0] p_acc;
    logic [RESW-1:0] th_res;
    logic [RESW-1:0] p_res;
    logic [TH_W-1:0] th_sat;
    logic [PH_W-1:0] p_sat;
    res_t            res_next;
    res_t            res_reg;
    data_t           yabs;

    // Stage 1: clamp x at zero, magnitude and sign of y
    always_comb
    begin
        xpos_next = (!d_in.x[DW-1] && (d_in.x != '0)) ? d_in.x[MW-1:0] : '0;
        yabs      = d_in.y[DW-1] ? -d_in.y : d_in.y;
        ymag_next = yabs[MW-1:0];
    end

    // Stage 2: partial products against 1/K, low half truncated by 16 bits
    assign th_lo_prod = LOPW'(xpos_reg[15:0]) * LOPW'(INV_GAIN_Q32);
    assign p_lo_prod  = LOPW'(ymag_reg[15:0]) * LOPW'(INV_GAIN_Q32);

    // Stage 3: sum, round half up, saturate, sign and null masking
    always_comb
    begin
        th_acc = ACCW'(th_hi_reg) + ACCW'(th_lo_reg) + ACCW'(64'd1 << (RSH - 1));
        p_acc  = ACCW'(p_hi_reg) + ACCW'(p_lo_reg) + ACCW'(64'd1 << (RSH - 1));
        th_res = th_acc[ACCW-1:RSH];
        p_res  = p_acc[ACCW-1:RSH];
        th_sat = (th_res > RESW'(THETA_MAX)) ? TH_W'(THETA_MAX) : th_res[TH_W-1:0];
        p_sat  = (p_res > RESW'(PHI_LIMIT)) ? PH_W'(PHI_LIMIT) : p_res[PH_W-1:0];
        res_next.vector_valid = tok2_reg.ok;
        res_next.theta        = tok2_reg.ok ? th_sat : '0;
        if (!tok2_reg.ok)
            res_next.phi = '0;
        else if (yneg2_reg)
            res_next.phi = -$signed(p_sat);
        else
            res_next.phi = $signed(p_sat);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok1_reg <= '0;
            tok2_reg <= '0;
            tok3_reg <= '0;
        end
        else if (en)
        begin
            tok1_reg <= tok_in;
            tok2_reg <= tok1_reg;
            tok3_reg <= tok2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xpos_reg  <= xpos_next;
            ymag_reg  <= ymag_next;
            yneg1_reg <= d_in.y[DW-1];
            th_hi_reg <= HIW'(xpos_reg[MW-1:16]) * HIW'(INV_GAIN_Q32);
            p_hi_reg  <= HIW'(ymag_reg[MW-1:16]) * HIW'(INV_GAIN_Q32);
            th_lo_reg <= th_lo_prod[LOPW-1:16];
            p_lo_reg  <= p_lo_prod[LOPW-1:16];
            yneg2_reg <= yneg1_reg;
            res_reg   <= res_next;
        end
    end

    assign tok_out = tok3_reg;
    assign res_out = res_reg;

endmodule

### design/stokes_qu_polarization_vector.sv
// Polarization vector from Stokes Q/U: top level with input stage, the two CORDIC
// cell chains, gain removal and the output skid buffer. Depends on sqpv_pkg and all cells.
`timescale 1ns / 1ps

// One pixel per clock cycle while the output is not stalled. Each accepted transaction
// yields exactly one result transaction, carried through one input register, one vectoring
// cell per stage, one rotation cell per stage, three gain-removal stages and the output
// register. The whole pipeline advances together; a one-entry skid register behind the
// output register keeps s_tready registered, so it drops in the cycle after m_tready is
// held low with a result waiting and another arriving. A pixel with either null flag
// gives vector_valid = 0 and zero components. No configuration, no state between
// pixels.

module stokes_qu_polarization_vector
    import sqpv_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // q_sample, u_sample
    input  logic [S_USER_W-1:0] s_tuser,   // q_is_null, u_is_null
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // theta_component, phi_component, zero pad
    output logic [M_USER_W-1:0] m_tuser    // vector_valid
);

    logic   adv;
    tok_t   ent_tok_reg;
    vec_t   ent_dat_reg;
    vec_t   ent_dat_next;
    data_t  q_ext;
    data_t  u_ext;
    data_t  q_abs;
    data_t  u_fold;

    tok_t   vtok [0:N_STAGES];
    vec_t   vdat [0:N_STAGES];
    tok_t   rtok [0:N_STAGES];
    rot_t   rdat [0:N_STAGES];

    tok_t   gtok;
    res_t   gres;

    logic   out_valid_reg;
    logic   out_valid_next;
    res_t   out_data_reg;
    res_t   out_data_next;
    logic   skid_valid_reg;
    logic   skid_valid_next;
    res_t   skid_data_reg;
    res_t   skid_data_next;
    logic   pipe_out_v;

    // Pipeline moves whenever the skid register is empty
    assign adv      = !skid_valid_reg;
    assign s_tready = adv;

    // Input stage: fold q to the right half plane, scale by guard bits
    always_comb
    begin
        q_ext  = DW'($signed(s_tdata[SAMPLE_WIDTH-1:0]));
        u_ext  = DW'($signed(s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]));
        q_abs  = q_ext[DW-1] ? -q_ext : q_ext;
        u_fold = q_ext[DW-1] ? -u_ext : u_ext;
        ent_dat_next.x0 = q_abs <<< GUARD_BITS;
        ent_dat_next.y0 = u_fold <<< GUARD_BITS;
        ent_dat_next.x  = ent_dat_next.x0;
        ent_dat_next.y  = ent_dat_next.y0;
        ent_dat_next.z  = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ent_tok_reg <= '0;
        else if (adv)
        begin
            ent_tok_reg.valid <= s_tvalid;
            ent_tok_reg.ok    <= !(s_tuser[0] || s_tuser[1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            ent_dat_reg <= ent_dat_next;
    end

    assign vtok[0] = ent_tok_reg;
    assign vdat[0] = ent_dat_reg;

    // Vectoring chain: angle of the folded vector
    for (genvar i = 0; i < N_STAGES; i++)
    begin : g_vec
        sqpv_vec_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .stage_idx (SIW'(i)),
            .tok_in    (vtok[i]),
            .d_in      (vdat[i]),
            .tok_out   (vtok[i+1]),
            .d_out     (vdat[i+1])
        );
    end

    // Rotation chain starts from the original vector and half the angle
    assign rtok[0]   = vtok[N_STAGES];
    assign rdat[0].x = vdat[N_STAGES].x0;
    assign rdat[0].y = vdat[N_STAGES].y0;
    assign rdat[0].r = vdat[N_STAGES].z >>> 1;

    for (genvar i = 0; i < N_STAGES; i++)
    begin : g_rot
        sqpv_rot_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .stage_idx (SIW'(i)),
            .tok_in    (rtok[i]),
            .d_in      (rdat[i]),
            .tok_out   (rtok[i+1]),
            .d_out     (rdat[i+1])
        );
    end

    sqpv_gain u_gain
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .tok_in  (rtok[N_STAGES]),
        .d_in    (rdat[N_STAGES]),
        .tok_out (gtok),
        .res_out (gres)
    );

    // Output register with skid entry
    assign pipe_out_v = gtok.valid && adv;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_next = pipe_out_v;
            out_data_next  = gres;
        end
        else if (pipe_out_v)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = gres;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_data_reg.vector_valid;
    assign m_tdata  = {{(M_DATA_W - TH_W - PH_W){1'b0}}, out_data_reg.phi,
                       out_data_reg.theta};

    // The skid entry only fills behind a held output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry occupied while output register empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready))
        else $error("skid entry filled although output was free");

    a_null_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("null pixel with nonzero components");

    a_theta_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_data_reg.theta <= TH_W'(THETA_MAX)))
        else $error("theta component above its limit");

endmodule

### tb/tb.sv
// Testbench for stokes_qu_polarization_vector: directed pixel table, then random pixels, each result
// checked against its written-out vector or a fixed-point CORDIC predictor. Depends on sqpv_pkg and the RTL.
`timescale 1ns / 1ps

module tb;

    localparam int  CLK_HALF        = 5;
    localparam int  CORDIC_STEPS    = 16;
    localparam int  GUARD           = 14;
    localparam int  PIPE_LATENCY    = 2 * CORDIC_STEPS + 5;
    localparam int  WATCHDOG_CYCLES = 1000;
    localparam int  THETA_CEIL      = 46341;
    localparam int  PHI_CEIL        = 32768;
    localparam longint unsigned RECIP_GAIN = 64'd2608131496;

    // atan(2^-i), 2^-32 turn units
    localparam longint ATAN_TURN [0:CORDIC_STEPS-1] = '{
        64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2E, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C
    };

    typedef struct packed {
        logic                vector_valid;
        logic [15:0]         theta;
        logic signed [16:0]  phi;
    } pol_vec_t;

    // One directed pixel; typed = 1 means the expected vector is written out
    typedef struct packed {
        logic [15:0] q;
        logic [15:0] u;
        logic        q_null;
        logic        u_null;
        logic        typed;
        pol_vec_t    vec;
    } pixel_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [sqpv_pkg::S_DATA_W-1:0] s_tdata;   // q_sample, u_sample
    logic [sqpv_pkg::S_USER_W-1:0] s_tuser;   // q_is_null, u_is_null
    logic m_tvalid;
    logic m_tready;
    logic [sqpv_pkg::M_DATA_W-1:0] m_tdata;   // theta_component, phi_component, zero pad
    logic [sqpv_pkg::M_USER_W-1:0] m_tuser;   // vector_valid

    pol_vec_t    vectors_due [$];
    pixel_row_t  pixel_table [$];
    logic        row_typed;
    pol_vec_t    row_vec;
    logic        src_idle;
    logic        sink_idle;
    int          mismatches;
    int          results_checked;
    int          null_pixels;
    int          quiet_cycles;

    stokes_qu_polarization_vector u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Magnitude times 1/K, back to Q1.15, round half up
    function automatic longint unsigned unscale_gain(input longint unsigned mag);
        longint unsigned hi;
        longint unsigned lo;
        longint unsigned acc;
        hi  = mag >> 16;
        lo  = mag & 64'hFFFF;
        acc = hi * RECIP_GAIN + ((lo * RECIP_GAIN) >> 16);
        return (acc + (64'd1 << (15 + GUARD))) >> (16 + GUARD);
    endfunction

    // Vectoring CORDIC on (|q|, u negated when q < 0), then rotation by minus half the angle
    function automatic pol_vec_t predict_pol_vector(input logic [15:0] qs, input logic [15:0] us,
                                                    input logic qn, input logic un);
        pol_vec_t        res;
        longint          q;
        longint          u;
        longint          x0;
        longint          y0;
        longint          xv;
        longint          yv;
        longint          z;
        longint          xr;
        longint          yr;
        longint          w;
        longint          t;
        longint          ph;
        longint unsigned th;
        longint unsigned pm;
        res = '0;
        if (qn || un)
            return res;
        q  = $signed(qs);
        u  = $signed(us);
        x0 = (q < 0 ? -q : q) <<< GUARD;
        y0 = (q < 0 ? -u : u) <<< GUARD;
        xv = x0;
        yv = y0;
        z  = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            t = xv;
            if (yv >= 0)
            begin
                xv = xv + (yv >>> i);
                yv = yv - (t >>> i);
                z  = z + ATAN_TURN[i];
            end
            else
            begin
                xv = xv - (yv >>> i);
                yv = yv + (t >>> i);
                z  = z - ATAN_TURN[i];
            end
        end
        w  = -(z >>> 1);
        xr = x0;
        yr = y0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            t = xr;
            if (w >= 0)
            begin
                xr = xr - (yr >>> i);
                yr = yr + (t >>> i);
                w  = w - ATAN_TURN[i];
            end
            else
            begin
                xr = xr + (yr >>> i);
                yr = yr - (t >>> i);
                w  = w + ATAN_TURN[i];
            end
        end
        th = (xr > 0) ? unscale_gain(xr) : 0;
        if (th > THETA_CEIL)
            th = THETA_CEIL;
        pm = unscale_gain(yr < 0 ? -yr : yr);
        if (pm > PHI_CEIL)
            pm = PHI_CEIL;
        ph = (yr < 0) ? -longint'(pm) : longint'(pm);
        res.vector_valid = 1'b1;
        res.theta        = th[15:0];
        res.phi          = ph[16:0];
        return res;
    endfunction

    // Random sample: zeros, extremes, small values and full-range values
    function automatic logic [15:0] random_sample();
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0:       v = 16'h0000;
            1:       v = ($urandom_range(0, 1) == 0) ? 16'h8000 : 16'h7FFF;
            2:       v = 16'($urandom_range(0, 511)) - 16'd256;
            3:       v = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'h0001;
            default: v = 16'($urandom());
        endcase
        return v;
    endfunction

    // Present one pixel, optionally after an idle gap, and hold it until accepted
    task automatic send_pixel(input logic [15:0] q, input logic [15:0] u, input logic qn,
                              input logic un, input logic typed, input pol_vec_t vec);
        int gap;
        @(negedge clk);
        if (src_idle && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 13);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= {u, q};
        s_tuser   <= {un, qn};
        row_typed <= typed;
        row_vec   <= vec;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_random_pixels(input int count);
        logic [15:0] q;
        logic [15:0] u;
        logic        qn;
        logic        un;
        for (int k = 0; k < count; k++)
        begin
            q  = random_sample();
            u  = random_sample();
            qn = ($urandom_range(0, 11) == 0);
            un = ($urandom_range(0, 11) == 0);
            send_pixel(q, u, qn, un, 1'b0, '0);
        end
    endtask

    // Receiver: ready with random stall bursts
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (sink_idle && $urandom_range(0, 9) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // Scoreboard: queue the expected vector per input transaction, check each output one
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                if (row_typed)
                    vectors_due.push_back(row_vec);
                else
                    vectors_due.push_back(predict_pol_vector(s_tdata[15:0], s_tdata[31:16],
                                                             s_tuser[0], s_tuser[1]));
                if (s_tuser[0] || s_tuser[1])
                    null_pixels++;
            end
            if (m_tvalid && m_tready)
            begin
                if (vectors_due.size() == 0)
                begin
                    $error("result transaction with no pixel outstanding");
                    mismatches++;
                end
                else
                begin
                    pol_vec_t want;
                    want = vectors_due.pop_front();
                    results_checked++;
                    if (m_tuser[0] !== want.vector_valid)
                    begin
                        $error("vector_valid expected %0d got %0d", want.vector_valid, m_tuser[0]);
                        mismatches++;
                    end
                    if (m_tdata[15:0] !== want.theta)
                    begin
                        $error("theta_component expected %0d got %0d", want.theta,
                               m_tdata[15:0]);
                        mismatches++;
                    end
                    if (m_tdata[32:16] !== want.phi)
                    begin
                        $error("phi_component expected %0d got %0d", want.phi,
                               $signed(m_tdata[32:16]));
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog: cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_CYCLES)
            begin
                $display("timeout: no transaction for %0d cycles", WATCHDOG_CYCLES);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = '0;
        row_typed       = 1'b0;
        row_vec         = '0;
        src_idle        = 1'b1;
        sink_idle       = 1'b1;
        mismatches      = 0;
        results_checked = 0;
        null_pixels     = 0;
        quiet_cycles    = 0;

        // Directed pixels: zero vector, full-scale corners, q = 0 with either sign of u,
        // unit steps, null flags on Q, U and both
        pixel_table.push_back('{16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1, '{1'b1, 16'd0, 17'sd0}});
        pixel_table.push_back('{16'h7FFF, 16'h0000, 1'b0, 1'b0, 1'b0, '0});
        pixel_table.push_back('{16'h8000, 16'h0000, 1'b0, 1'b0, 1'b0, '0});
        pixel_table.push_back('{16'h0000, 16'h7FFF, 1'b0, 1'b0, 1'b0, '0});
        pixel_table.push_back('{16'h0000, 16'h8000, 1'b0, 1'b0, 1'b0, '0});
        pixel_table.push_back('{16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 1'b0, '0});
        pixel_table.push_back('{16'h8000, 16'h8000, 1'b0, 1'b0, 1'b0, '0});
        pixel_table.push_back('{16'h8000, 16'h7FFF, 1'b0, 1'b0, 1'b0, '0});
        pixel_table.push_back('{16'h7FFF, 16'h8000, 1'b0, 1'b0, 1'b0, '0});
        pixel_table.push_back('{16'hFFFF, 16'h0001, 1'b0, 1'b0, 1'b0, '0});
        pixel_table.push_back('{16'h0001, 16'hFFFF, 1'b0, 1'b0, 1'b0, '0});
        pixel_table.push_back('{16'h0001, 16'h0001, 1'b0, 1'b0, 1'b0, '0});
        pixel_table.push_back('{16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0, '0});
        pixel_table.push_back('{16'h0000, 16'h0001, 1'b0, 1'b0, 1'b0, '0});
        pixel_table.push_back('{16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b0, '0});
        pixel_table.push_back('{16'h1234, 16'hABCD, 1'b1, 1'b0, 1'b1, '0});
        pixel_table.push_back('{16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b1, '0});
        pixel_table.push_back('{16'h8000, 16'h7FFF, 1'b1, 1'b1, 1'b1, '0});
        pixel_table.push_back('{16'h0000, 16'h0000, 1'b1, 1'b0, 1'b1, '0});
        pixel_table.push_back('{16'h5A5A, 16'hA5A5, 1'b0, 1'b0, 1'b0, '0});
        pixel_table.push_back('{16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1, '{1'b1, 16'd0, 17'sd0}});

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (pixel_table[k])
            send_pixel(pixel_table[k].q, pixel_table[k].u, pixel_table[k].q_null,
                       pixel_table[k].u_null, pixel_table[k].typed, pixel_table[k].vec);

        send_random_pixels(800);

        // Sender holds off until the pipeline has drained
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (vectors_due.size() != 0)
            @(posedge clk);

        send_random_pixels(400);

        // Closing stretch at full rate on both sides
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        send_random_pixels(430);

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (vectors_due.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 13) @(posedge clk);

        $display("checked %0d polarization vectors, %0d from pixels with a null flag,",
                 results_checked, null_pixels);
        $display("covering full-scale corners, q = 0, zero vectors and stalls on both sides");
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### sim.f
design/sqpv_pkg.sv
design/sqpv_vec_cell.sv
design/sqpv_rot_cell.sv
design/sqpv_gain.sv
design/stokes_qu_polarization_vector.sv
tb/tb.sv
